FILE: rtl/core/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths and reset constants shared by the exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int unsigned DATA_WIDTH = 32;

  localparam logic [DATA_WIDTH-1:0] RESET_MODULUS = 32'd1000000007;

endpackage

FILE: rtl/core/mexp_mulmod.sv
// ----------------------------------------------------------------------------
// Bit-serial modular multiplier
// Computes x * y mod m by interleaved reduction, one bit of x per cycle,
// most significant bit first. The modulus input is Width+1 bits so that a
// modulus of 2^Width can be expressed.
// ----------------------------------------------------------------------------
module mexp_mulmod #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] x_i,
  input  logic [Width-1:0] y_i,
  input  logic [Width:0]   m_i,
  output logic             done_o,
  output logic [Width-1:0] prod_o
);

  localparam int unsigned CntW = (Width > 1) ? $clog2(Width) : 1;

  logic             busy_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [Width-1:0] xs_q;
  logic [Width-1:0] y_q;
  logic [Width-1:0] r_q;

  logic [Width+1:0] m_ext;
  logic [Width+1:0] t_sum;
  logic [Width+1:0] t_one;
  logic [Width+1:0] t_two;

  always_comb begin
    m_ext = (Width+2)'(m_i);
    t_sum = {1'b0, r_q, 1'b0} + (xs_q[Width-1] ? {2'b00, y_q} : '0);
    t_one = (t_sum >= m_ext) ? (t_sum - m_ext) : t_sum;
    t_two = (t_one >= m_ext) ? (t_one - m_ext) : t_one;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xs_q <= x_i;
      y_q  <= y_i;
      r_q  <= '0;
    end else if (busy_q) begin
      xs_q <= {xs_q[Width-2:0], 1'b0};
      r_q  <= t_two[Width-1:0];
    end
  end

  assign done_o = done_q;
  assign prod_o = r_q;

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("Multiplier started while busy.");

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q))
    else $error("Product completion without a running multiplication.");

  a_residue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ((Width+1)'(r_q) < m_i))
    else $error("Product not reduced below the modulus.");

endmodule

FILE: rtl/core/modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// Modular exponentiation, top level
// Computes base ^ exponent mod modulus by square-and-multiply over a
// bit-serial modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
// A request carries base_i and exponent_i on a valid/ready channel and gives
// one power_mod_o result on a valid/ready output channel. The modulus is
// written through cfg_we_i/cfg_wdata_i; the user must write it only while
// the block is idle, which it does not enforce. A value of zero stands for
// 2^OPERAND_WIDTH. Only the low OPERAND_WIDTH bits of the operands
// and modulus are used. One request is processed at a time. The base is
// first reduced, then the exponent is scanned from its top bit: one squaring
// per bit and one more multiplication per set bit, all on the shared
// bit-serial multiplier. A zero exponent gives 1 directly, with no
// multiplication at all.
// A new request is taken while the previous result still waits in the
// output register; a stalled receiver holds the finished result and the
// next one waits until it is taken. Reset loads the modulus 1000000007 and
// empties the output register.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mexp_pkg::DATA_WIDTH-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [mexp_pkg::DATA_WIDTH-1:0]  base_i,
  input  logic [mexp_pkg::DATA_WIDTH-1:0]  exponent_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [mexp_pkg::DATA_WIDTH-1:0]  power_mod_o
);

  import mexp_pkg::*;

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned CntW = (W > 1) ? $clog2(W) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_SQR,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e          state_q;
  logic [W-1:0]    modulus_q;
  logic [W:0]      m_ext;
  logic [W-1:0]    e_q;
  logic [CntW-1:0] ebit_q;
  logic [W-1:0]    acc_q;
  logic [W-1:0]    rb_q;
  logic            mul_start_q;
  logic [W-1:0]    mul_x_q;
  logic [W-1:0]    mul_y_q;
  logic            mul_done;
  logic [W-1:0]    mul_prod;
  logic            out_valid_q;
  logic [W-1:0]    out_data_q;
  logic            in_fire;

  assign m_ext   = (modulus_q == '0) ? {1'b1, {W{1'b0}}} : {1'b0, modulus_q};
  assign in_fire = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= RESET_MODULUS[W-1:0];
    end else if (cfg_we_i) begin
      modulus_q <= cfg_wdata_i[W-1:0];
    end
  end

  mexp_mulmod #(
    .Width(W)
  ) u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start_q),
    .x_i    (mul_x_q),
    .y_i    (mul_y_q),
    .m_i    (m_ext),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_start_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      ebit_q      <= '0;
      e_q         <= '0;
      acc_q       <= '0;
      rb_q        <= '0;
      mul_x_q     <= '0;
      mul_y_q     <= '0;
    end else begin
      if (out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          mul_start_q <= in_fire && (exponent_i[W-1:0] != '0);
          if (in_fire) begin
            e_q    <= exponent_i[W-1:0];
            acc_q  <= W'(1);
            ebit_q <= CntW'(W - 1);
            if (exponent_i[W-1:0] == '0) begin
              state_q <= ST_DONE;
            end else begin
              mul_x_q <= base_i[W-1:0];
              mul_y_q <= W'(1);
              state_q <= ST_BASE;
            end
          end
        end
        ST_BASE: begin
          mul_start_q <= mul_done;
          if (mul_done) begin
            rb_q    <= mul_prod;
            mul_x_q <= acc_q;
            mul_y_q <= acc_q;
            state_q <= ST_SQR;
          end
        end
        ST_SQR, ST_MUL: begin
          if (mul_done) begin
            acc_q <= mul_prod;
            if (state_q == ST_SQR && e_q[W-1]) begin
              mul_x_q     <= mul_prod;
              mul_y_q     <= rb_q;
              mul_start_q <= 1'b1;
              state_q     <= ST_MUL;
            end else if (ebit_q == '0) begin
              mul_start_q <= 1'b0;
              state_q     <= ST_DONE;
            end else begin
              ebit_q      <= ebit_q - 1'b1;
              e_q         <= {e_q[W-2:0], 1'b0};
              mul_x_q     <= mul_prod;
              mul_y_q     <= mul_prod;
              mul_start_q <= 1'b1;
              state_q     <= ST_SQR;
            end
          end else begin
            mul_start_q <= 1'b0;
          end
        end
        ST_DONE: begin
          mul_start_q <= 1'b0;
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_data_q  <= acc_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          mul_start_q <= 1'b0;
          state_q     <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign power_mod_o = DATA_WIDTH'(out_data_q);

  a_zero_exponent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && exponent_i[W-1:0] == '0) |=> (state_q == ST_DONE) && (acc_q == W'(1)))
    else $error("Zero exponent did not yield one directly.");

  a_start_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start_q |-> (state_q == ST_BASE || state_q == ST_SQR || state_q == ST_MUL))
    else $error("Multiplication launched outside of a working state.");

  a_done_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_BASE || state_q == ST_SQR || state_q == ST_MUL))
    else $error("Product returned outside of a working state.");

  a_base_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) |-> ((W+1)'(rb_q) < m_ext))
    else $error("Reduced base not below the modulus.");

endmodule

FILE: tb/sv/tb_modular_exponentiation_top.sv
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Sends base/exponent requests through the valid/ready input channel under
// several modulus settings, predicts each power by square-and-multiply and
// checks every result in order. Both channels idle at random, and the output
// is held off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mexp_pkg::*;

  localparam int unsigned W                = DATA_WIDTH;
  localparam int unsigned CYCLE_LIMIT      = 3_000_000;
  localparam int unsigned LONG_HOLD        = 8000;
  localparam int unsigned HOLD_AFTER       = 80;
  localparam int unsigned DRAIN_CYCLES     = 2400;
  localparam int unsigned RANDOM_PHASES    = 7;
  localparam int unsigned RANDOM_PER_PHASE = 38;

  typedef logic [W-1:0] word_t;

  typedef struct packed {
    word_t base;
    word_t exponent;
  } operands_t;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  cfg_we_i    = 1'b0;
  word_t cfg_wdata_i = '0;
  logic  in_valid_i  = 1'b0;
  word_t base_i      = '0;
  word_t exponent_i  = '0;
  logic  out_ready_i = 1'b0;
  logic  in_ready_o;
  logic  out_valid_o;
  word_t power_mod_o;

  operands_t   pending_operands[$];
  word_t       expected_powers[$];
  word_t       model_modulus = RESET_MODULUS;
  bit          request_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned request_count = 0;
  int unsigned zero_exponent_count = 0;
  int unsigned result_count = 0;
  int unsigned modulus_writes = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned stall_left = 0;
  logic [31:0] stall_mask = '1;

  modular_exponentiation_top #(
    .OPERAND_WIDTH(W)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .base_i     (base_i),
    .exponent_i (exponent_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .power_mod_o(power_mod_o)
  );

  // A modulus of zero stands for 2^W, so the value simply wraps.
  function automatic logic [63:0] reduce_mod(logic [63:0] value, word_t modulus);
    if (modulus == '0) begin
      return 64'(value[W-1:0]);
    end
    return value % 64'(modulus);
  endfunction

  function automatic word_t predict_power_mod(operands_t op, word_t modulus);
    logic [63:0] acc;
    logic [63:0] reduced_base;
    if (op.exponent == '0) begin
      return word_t'(1);
    end
    reduced_base = reduce_mod(64'(op.base), modulus);
    acc = 64'd1;
    for (int i = W - 1; i >= 0; i--) begin
      acc = reduce_mod(acc * acc, modulus);
      if (op.exponent[i]) begin
        acc = reduce_mod(acc * reduced_base, modulus);
      end
    end
    return acc[W-1:0];
  endfunction

  task automatic queue_request(word_t base, word_t exponent);
    operands_t op;
    op.base          = base;
    op.exponent      = exponent;
    pending_operands = {pending_operands, op};
  endtask

  task automatic queue_random_requests(int unsigned count);
    operands_t op;
    for (int unsigned k = 0; k < count; k++) begin
      op.base     = $urandom();
      op.exponent = $urandom();
      case ($urandom_range(0, 9))
        0: op.base = model_modulus;
        1: op.base = model_modulus - 1'b1;
        2: op.base = $urandom_range(0, 2);
        3: op.exponent = $urandom_range(0, 3);
        4: op.exponent = word_t'('1) >> $urandom_range(0, W - 1);
        5: op.exponent = word_t'(1) << $urandom_range(0, W - 1);
        default: ;
      endcase
      pending_operands = {pending_operands, op};
    end
  endtask

  task automatic wait_until_idle();
    do begin
      @(posedge clk_i);
    end while (pending_operands.size() != 0 || in_valid_i || expected_powers.size() != 0);
  endtask

  task automatic write_modulus(word_t value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model_modulus = value;
    modulus_writes++;
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    word_t expected_power;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** modular_exponentiation_top: FAILED **");
      $finish;
    end else if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_power  = predict_power_mod('{base: base_i, exponent: exponent_i},
                                            model_modulus);
        expected_powers = {expected_powers, expected_power};
        request_taken = 1'b1;
        request_count++;
        if (exponent_i == '0) begin
          zero_exponent_count++;
        end
      end
      if (out_valid_o && out_ready_i) begin
        result_count++;
        if (expected_powers.size() == 0) begin
          $error("power_mod: result %h arrived with no request outstanding", power_mod_o);
          mismatch_count++;
        end else begin
          expected_power = expected_powers.pop_front();
          if (power_mod_o !== expected_power) begin
            $error("power_mod mismatch: expected %h, actual %h", expected_power, power_mod_o);
            mismatch_count++;
          end
        end
      end
    end
  end

  // The sender offers requests in bursts separated by random gaps.
  always @(negedge clk_i) begin
    operands_t next_op;
    if (rst_ni && (!in_valid_i || request_taken)) begin
      request_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_operands.size() > 0) begin
        next_op = pending_operands.pop_front();
        in_valid_i <= 1'b1;
        base_i     <= next_op.base;
        exponent_i <= next_op.exponent;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // The receiver follows a rotating stall mask, and once holds off long enough
  // for the block to fill and refuse further requests.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && result_count >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready_i <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_left = 64;
        stall_mask = ($urandom_range(0, 2) == 0) ? '1 : ($urandom() | $urandom());
      end
      stall_left--;
      out_ready_i <= stall_mask[0];
      stall_mask = {stall_mask[0], stall_mask[31:1]};
    end
  end

  initial begin
    word_t phase_moduli[RANDOM_PHASES];
    phase_moduli[0] = 32'hFFFF_FFFF;
    phase_moduli[1] = $urandom() | 32'h8000_0000;
    phase_moduli[2] = 32'd65537;
    phase_moduli[3] = $urandom_range(3, 1000);
    phase_moduli[4] = '0;
    phase_moduli[5] = $urandom_range(2, 32'h7FFF_FFFF);
    phase_moduli[6] = RESET_MODULUS;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    queue_request(32'h0000_0000, 32'h0000_0000);
    queue_request(32'hFFFF_FFFF, 32'h0000_0000);
    queue_request(32'h0000_0000, 32'h0000_0001);
    queue_request(32'h0000_0000, 32'hFFFF_FFFF);
    queue_request(32'd2, 32'd10);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_request(32'd1000000007, 32'd5);
    queue_request(32'd1000000008, 32'd2);
    queue_request(32'd2, 32'h8000_0000);
    queue_request(32'hDEAD_BEEF, 32'h5555_5555);
    wait_until_idle();

    write_modulus(32'd1);
    queue_request(32'd7, 32'd0);
    queue_request(32'd5, 32'd3);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_until_idle();

    write_modulus('0);
    queue_request(32'd3, 32'hFFFF_FFFF);
    queue_request(32'hFFFF_FFFF, 32'd2);
    queue_request(32'd2, 32'd31);
    queue_request(32'd2, 32'd32);
    queue_request(32'h1234_5678, 32'd0);
    wait_until_idle();

    write_modulus(32'hFFFF_FFFF);
    queue_request(32'hFFFF_FFFF, 32'd5);
    queue_request(32'hFFFF_FFFE, 32'd2);
    queue_request(32'hFFFF_FFFE, 32'd3);
    queue_request(32'hABCD_EF01, 32'hAAAA_AAAA);
    wait_until_idle();

    write_modulus(32'd2);
    queue_request(32'd3, 32'd7);
    queue_request(32'd4, 32'd9);
    wait_until_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_modulus(phase_moduli[p]);
      queue_random_requests(RANDOM_PER_PHASE);
      wait_until_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests (%0d with a zero exponent) across %0d modulus writes.",
             request_count, zero_exponent_count, modulus_writes);
    $display("Results checked: %0d, mismatches: %0d.", result_count, mismatch_count);
    if (mismatch_count == 0 && expected_powers.size() == 0) begin
      $display("** modular_exponentiation_top: PASSED **");
    end else begin
      $display("** modular_exponentiation_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/mexp_pkg.sv
rtl/core/mexp_mulmod.sv
rtl/core/modular_exponentiation_top.sv
tb/sv/tb_modular_exponentiation_top.sv
